// File: rtl/emtu_pkg.sv
// Shared types and constants for the multi-turn encoder tracker.
`default_nettype none
package emtu_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_SHAFT_ZERO     = 3'd0;
    localparam cfg_index_t REG_ROTOR_ZERO     = 3'd1;
    localparam cfg_index_t REG_POLE_PAIRS     = 3'd2;
    localparam cfg_index_t REG_JUMP_THRESHOLD = 3'd3;

    localparam int POLE_BITS = 7;
    localparam int POLE_PRODUCT_BITS = 6;
    localparam logic [POLE_BITS-1:0] POLE_PAIRS_RESET = 7'd7;
    localparam logic [POLE_BITS-1:0] POLE_PAIRS_CAP = 7'd64;

    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/emtu_cfg_regs.sv
// Configuration register file of the multi-turn encoder tracker.
`default_nettype none
module emtu_cfg_regs #(
    parameter int ANGLE_BITS = 14
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire emtu_pkg::cfg_index_t     cfg_index,
    input  wire logic [ANGLE_BITS-1:0]    cfg_data,
    output logic [ANGLE_BITS-1:0]         shaft_zero,
    output logic [ANGLE_BITS-1:0]         rotor_zero,
    output logic [emtu_pkg::POLE_BITS-1:0] pole_pairs,
    output logic [ANGLE_BITS-1:0]         jump_threshold
);
    import emtu_pkg::*;

    localparam logic [ANGLE_BITS-1:0] THRESHOLD_RESET =
        ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    logic [ANGLE_BITS-1:0] shaft_zero_reg;
    logic [ANGLE_BITS-1:0] rotor_zero_reg;
    logic [POLE_BITS-1:0]  pole_pairs_reg;
    logic [ANGLE_BITS-1:0] jump_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaft_zero_reg     <= '0;
            rotor_zero_reg     <= '0;
            pole_pairs_reg     <= POLE_PAIRS_RESET;
            jump_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHAFT_ZERO:     shaft_zero_reg     <= cfg_data;
                REG_ROTOR_ZERO:     rotor_zero_reg     <= cfg_data;
                REG_POLE_PAIRS:     pole_pairs_reg     <= cfg_data[POLE_BITS-1:0];
                REG_JUMP_THRESHOLD: jump_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign shaft_zero     = shaft_zero_reg;
    assign rotor_zero     = rotor_zero_reg;
    assign pole_pairs     = pole_pairs_reg;
    assign jump_threshold = jump_threshold_reg;

endmodule
`default_nettype wire

// File: rtl/emtu_track_core.sv
// Offset, wrap detection, saturating revolution count and rotor angle product.
`default_nettype none
module emtu_track_core #(
    parameter int ANGLE_BITS = 14,
    parameter int REV_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire emtu_pkg::pipe_ctrl_t              ctrl,
    input  wire logic [ANGLE_BITS-1:0]             raw,
    input  wire logic [ANGLE_BITS-1:0]             shaft_zero,
    input  wire logic [ANGLE_BITS-1:0]             rotor_zero,
    input  wire logic [emtu_pkg::POLE_BITS-1:0]    pole_pairs,
    input  wire logic [ANGLE_BITS-1:0]             jump_threshold,
    output logic signed [REV_BITS+ANGLE_BITS-1:0]  position_next,
    output logic signed [REV_BITS-1:0]             revolutions_next,
    output logic [ANGLE_BITS+emtu_pkg::POLE_PRODUCT_BITS-1:0] rotor_next
);
    import emtu_pkg::*;

    localparam logic signed [REV_BITS-1:0] REV_MAX = {1'b0, {(REV_BITS-1){1'b1}}};
    localparam logic signed [REV_BITS-1:0] REV_MIN = {1'b1, {(REV_BITS-1){1'b0}}};

    logic [ANGLE_BITS-1:0]        prev_shaft_reg;
    logic signed [REV_BITS-1:0]   rev_count_reg;

    logic [ANGLE_BITS-1:0]        shaft;
    logic [ANGLE_BITS-1:0]        rotor;
    logic signed [ANGLE_BITS:0]   step;
    logic [ANGLE_BITS:0]          mag;
    logic                         wrap;
    logic [POLE_BITS-1:0]         pp;
    logic [ANGLE_BITS+POLE_BITS-1:0] product;

    always_comb
    begin
        shaft = raw - shaft_zero;
        rotor = raw - rotor_zero;
        step  = $signed({1'b0, shaft}) - $signed({1'b0, prev_shaft_reg});
        mag   = step[ANGLE_BITS] ? (ANGLE_BITS+1)'(-step) : step;
        wrap  = mag > {1'b0, jump_threshold};
        pp    = (pole_pairs > POLE_PAIRS_CAP) ? POLE_PAIRS_CAP : pole_pairs;

        revolutions_next = rev_count_reg;
        if (wrap)
        begin
            if (!step[ANGLE_BITS])
            begin
                if (rev_count_reg != REV_MIN)
                begin
                    revolutions_next = rev_count_reg - REV_BITS'(1);
                end
            end
            else if (rev_count_reg != REV_MAX)
            begin
                revolutions_next = rev_count_reg + REV_BITS'(1);
            end
        end

        position_next = {revolutions_next, shaft};
        product       = rotor * pp;
        rotor_next    = product[ANGLE_BITS+POLE_PRODUCT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_shaft_reg <= '0;
            rev_count_reg  <= '0;
        end
        else if (ctrl.advance)
        begin
            prev_shaft_reg <= shaft;
            rev_count_reg  <= revolutions_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/encoder_multiturn_tracker_unit.sv
// Top level of the multi-turn encoder tracker: input register, tracking stage, result register.
`default_nettype none
// The block takes one raw angle sample per transaction and returns one result per sample:
// the multi-turn shaft position, the saturating revolution count and the electrical rotor
// angle. It sustains one transaction per clock cycle while the output is not stalled; the
// rate is set by the revolution count update, which closes its loop inside the tracking
// stage between the input register and the result register. A sample is held in the
// input register while the result register is full and stalled. Configuration
// writes are always ready and take effect on the next sample.
module encoder_multiturn_tracker_unit #(
    parameter int ANGLE_BITS = 14,
    parameter int REV_BITS   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [ANGLE_BITS-1:0]                 raw_angle,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [REV_BITS+ANGLE_BITS-1:0]      shaft_position,
    output logic signed [REV_BITS-1:0]                 revolutions,
    output logic [ANGLE_BITS+emtu_pkg::POLE_PRODUCT_BITS-1:0] rotor_electrical,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire emtu_pkg::cfg_index_t                  cfg_index,
    input  wire logic [ANGLE_BITS-1:0]                 cfg_data
);
    import emtu_pkg::*;

    localparam int ROTOR_BITS = ANGLE_BITS + POLE_PRODUCT_BITS;

    logic [ANGLE_BITS-1:0] shaft_zero;
    logic [ANGLE_BITS-1:0] rotor_zero;
    logic [POLE_BITS-1:0]  pole_pairs;
    logic [ANGLE_BITS-1:0] jump_threshold;

    logic                  s1_valid_reg;
    logic [ANGLE_BITS-1:0] raw_reg;
    logic                  out_valid_reg;
    logic signed [REV_BITS+ANGLE_BITS-1:0] position_reg;
    logic signed [REV_BITS-1:0]            revolutions_reg;
    logic [ROTOR_BITS-1:0]                 rotor_reg;

    logic signed [REV_BITS+ANGLE_BITS-1:0] position_next;
    logic signed [REV_BITS-1:0]            revolutions_next;
    logic [ROTOR_BITS-1:0]                 rotor_next;

    logic       out_room;
    pipe_ctrl_t ctrl;

    assign out_room     = !out_valid_reg || !out_stall;
    assign ctrl.advance  = s1_valid_reg && out_room;
    assign in_stall      = s1_valid_reg && !out_room;

    emtu_cfg_regs #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .shaft_zero     (shaft_zero),
        .rotor_zero     (rotor_zero),
        .pole_pairs     (pole_pairs),
        .jump_threshold (jump_threshold)
    );

    emtu_track_core #(
        .ANGLE_BITS (ANGLE_BITS),
        .REV_BITS   (REV_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .raw              (raw_reg),
        .shaft_zero       (shaft_zero),
        .rotor_zero       (rotor_zero),
        .pole_pairs       (pole_pairs),
        .jump_threshold   (jump_threshold),
        .position_next    (position_next),
        .revolutions_next (revolutions_next),
        .rotor_next       (rotor_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_room)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            raw_reg <= raw_angle;
        end
        if (ctrl.advance)
        begin
            position_reg    <= position_next;
            revolutions_reg <= revolutions_next;
            rotor_reg       <= rotor_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign shaft_position   = position_reg;
    assign revolutions      = revolutions_reg;
    assign rotor_electrical = rotor_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("Input stalled while the pipeline has room.");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |=> out_valid_reg)
        else $error("Tracked sample did not reach the result register.");

    a_position_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (shaft_position[REV_BITS+ANGLE_BITS-1:ANGLE_BITS] == revolutions))
        else $error("Shaft position disagrees with the revolution count.");

endmodule
`default_nettype wire
